### rtl/core/tts_pkg.sv
// Shared types, byte codes and the ignorable-codepoint ROM for the terminal
// text sanitizer. Used by the parser and by the top level; no dependencies.
`default_nettype none

package tts_pkg;

  // Most output bytes one input byte can cause (a tab at full width).
  localparam int unsigned MAX_RESULTS     = 8;
  localparam int unsigned CNT_W           = 4;
  localparam int unsigned NUM_DROP_RANGES = 19;

  // Byte codes the parser looks at.
  localparam logic [7:0] BYTE_BEL   = 8'h07;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] BYTE_CSI   = 8'h5B;  // '['
  localparam logic [7:0] BYTE_OSC   = 8'h5D;  // ']'
  localparam logic [7:0] BYTE_DCS   = 8'h50;  // 'P'
  localparam logic [7:0] BYTE_SOS   = 8'h58;  // 'X'
  localparam logic [7:0] BYTE_PM    = 8'h5E;  // '^'
  localparam logic [7:0] BYTE_APC   = 8'h5F;  // '_'

  // Codepoint limits.
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_LSEP      = 21'h002028;
  localparam logic [20:0] CP_PSEP      = 21'h002029;
  localparam logic [20:0] CP_C1_LO     = 21'h000080;
  localparam logic [20:0] CP_C1_HI     = 21'h00009F;
  localparam logic [20:0] CP_MIN_2BYTE = 21'h000080;
  localparam logic [20:0] CP_MIN_3BYTE = 21'h000800;
  localparam logic [20:0] CP_MIN_4BYTE = 21'h010000;

  // Bytes produced by one accepted input byte, lowest byte leaves first.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [31:0]      bytes;
  } emit_t;

  // Inclusive ranges of codepoints that are dropped from the output.
  localparam logic [20:0] DROP_FIRST [NUM_DROP_RANGES] = '{
    21'h000AD, 21'h0034F, 21'h0061C, 21'h0115F, 21'h017B4, 21'h0180B, 21'h0200B,
    21'h0202A, 21'h02060, 21'h020E3, 21'h03164, 21'h0FE00, 21'h0FEFF, 21'h0FFA0,
    21'h0FFF0, 21'h1BCA0, 21'h1D173, 21'h1F3FB, 21'hE0000
  };
  localparam logic [20:0] DROP_LAST [NUM_DROP_RANGES] = '{
    21'h000AD, 21'h0034F, 21'h0061C, 21'h01160, 21'h017B5, 21'h0180F, 21'h0200F,
    21'h0202E, 21'h0206F, 21'h020E3, 21'h03164, 21'h0FE0F, 21'h0FEFF, 21'h0FFA0,
    21'h0FFF8, 21'h1BCA3, 21'h1D17A, 21'h1F3FF, 21'hE0FFF
  };

  // True when the codepoint falls in any of the ignorable ranges.
  function automatic logic in_drop_rom(input logic [20:0] cp);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_DROP_RANGES; k++) begin
      if (cp >= DROP_FIRST[k] && cp <= DROP_LAST[k]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

### rtl/core/terminal_text_sanitizer_core.sv
// Top level of the terminal text sanitizer: stream ports, tab width register
// and the output byte buffer. Uses tts_pkg and tts_parse.
`default_nettype none

// One input byte is accepted per cycle whenever the output side keeps up. A
// byte that produces n output bytes (n from 0 to 8: a tab gives tab_width
// spaces, capped at eight, and a UTF-8 sequence gives up to four bytes) holds
// the output buffer until its n bytes have gone out, and the next input byte is
// taken in the cycle its last byte transfers out. Bytes with no output do not wait.
// The parser works on the byte at the edge of its transfer; the results sit
// in a four-byte shift buffer that drives the output channel.
module terminal_text_sanitizer_core
  import tts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input channel.
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // end_of_text
  // Output channel.
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,  // out_last
  // Configuration.
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata   // tab_width
);

  logic [3:0]       tab_width_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      buf_r;
  logic             in_take;
  logic             out_take;
  emit_t            emit;

  // Tab width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r <= 4'd4;
    end else if (cfg_we) begin
      tab_width_r <= cfg_wdata;
    end
  end

  // A new byte may enter once the buffer is empty or giving its last byte.
  assign in_tready = (cnt_r == '0) || (cnt_r == 4'd1 && out_tready);
  assign in_take   = in_tvalid && in_tready;
  assign out_take  = out_tvalid && out_tready;

  tts_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (in_take),
    .in_byte     (in_tdata),
    .end_of_text (in_tlast),
    .tab_width   (tab_width_r),
    .emit        (emit)
  );

  // Output byte count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_take) begin
      cnt_r <= emit.count;
    end else if (out_take) begin
      cnt_r <= cnt_r - 4'd1;
    end
  end

  // Output byte buffer; spaces shift in behind, which serves tab expansion.
  always_ff @(posedge clk) begin
    if (in_take) begin
      buf_r <= emit.bytes;
    end else if (out_take) begin
      buf_r <= {BYTE_SPACE, buf_r[31:8]};
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = buf_r[7:0];
  assign out_tlast  = (cnt_r == 4'd1);

`ifndef SYNTHESIS
  // The pending byte count never exceeds what one input can cause.
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'(MAX_RESULTS))
    else $error("tts core: output count above limit");

  // A non-final byte of an item is always followed by more output.
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && !out_tlast |=> out_tvalid)
    else $error("tts core: item ended without a last byte");

  // A transfer with no new input retires exactly one byte.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && !in_take |=> cnt_r == $past(cnt_r) - 4'd1)
    else $error("tts core: output count did not step");
`endif

endmodule

`default_nettype wire

### rtl/core/tts_parse.sv
// Escape and UTF-8 parser of the terminal text sanitizer: holds the parse
// state and turns one accepted byte into the bytes it emits. Uses tts_pkg.
`default_nettype none

module tts_parse
  import tts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_text,
  input  wire logic [3:0] tab_width,
  output emit_t           emit
);

  typedef enum logic [5:0] {
    MODE_GROUND    = 6'b000001,
    MODE_UTF8      = 6'b000010,
    MODE_ESC_START = 6'b000100,
    MODE_CSI       = 6'b001000,
    MODE_STRING    = 6'b010000,
    MODE_INTERMED  = 6'b100000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [7:0]  held_r   [3];
  logic [7:0]  held_nxt [3];

  logic        run_ground;
  logic [20:0] cp_cont;
  logic        bad_seq;
  logic        is_cont;
  logic [3:0]  tab_count;

  assign cp_cont   = {cp_r[14:0], in_byte[5:0]};
  assign is_cont   = (in_byte[7:6] == 2'b10);
  assign tab_count = (tab_width > 4'(MAX_RESULTS)) ? 4'(MAX_RESULTS) : tab_width;

  // Overlong forms, surrogates and values past the last codepoint.
  assign bad_seq = (hcnt_r == 2'd1 && cp_cont < CP_MIN_2BYTE) ||
                   (hcnt_r == 2'd2 && cp_cont < CP_MIN_3BYTE) ||
                   (hcnt_r == 2'd3 && cp_cont < CP_MIN_4BYTE) ||
                   (cp_cont >= CP_SURR_LO && cp_cont <= CP_SURR_HI) ||
                   (cp_cont > CP_MAX);

  // Next parse state and the bytes this input causes.
  always_comb begin
    mode_nxt    = mode_r;
    need_nxt    = need_r;
    hcnt_nxt    = hcnt_r;
    cp_nxt      = cp_r;
    held_nxt    = held_r;
    emit.count  = '0;
    emit.bytes  = {4{BYTE_SPACE}};
    run_ground  = 1'b0;

    case (mode_r)
      MODE_UTF8: begin
        if (is_cont) begin
          cp_nxt = cp_cont;
          if (need_r > 2'd1) begin
            need_nxt = need_r - 2'd1;
            hcnt_nxt = hcnt_r + 2'd1;
            case (hcnt_r)
              2'd0:    held_nxt[0] = in_byte;
              2'd1:    held_nxt[1] = in_byte;
              2'd2:    held_nxt[2] = in_byte;
              default: ;
            endcase
          end else begin
            // Last continuation byte: check the codepoint, then drop it, give a space for a separator, or re-emit it.
            mode_nxt = MODE_GROUND;
            need_nxt = 2'd0;
            if (bad_seq || (cp_cont >= CP_C1_LO && cp_cont <= CP_C1_HI)) begin
              emit.count = '0;
            end else if (cp_cont == CP_LSEP || cp_cont == CP_PSEP) begin
              emit.count = 4'd1;
            end else if (in_drop_rom(cp_cont)) begin
              emit.count = '0;
            end else begin
              emit.count = {2'b00, hcnt_r} + 4'd1;
              case (hcnt_r)
                2'd0:    emit.bytes = {BYTE_SPACE, BYTE_SPACE, BYTE_SPACE, in_byte};
                2'd1:    emit.bytes = {BYTE_SPACE, BYTE_SPACE, in_byte, held_r[0]};
                2'd2:    emit.bytes = {BYTE_SPACE, in_byte, held_r[1], held_r[0]};
                default: emit.bytes = {in_byte, held_r[2], held_r[1], held_r[0]};
              endcase
            end
          end
        end else begin
          run_ground = 1'b1;
        end
      end
      MODE_ESC_START: begin
        if (in_byte == BYTE_CSI) begin
          mode_nxt = MODE_CSI;
        end else if (in_byte == BYTE_OSC || in_byte == BYTE_DCS || in_byte == BYTE_SOS ||
                     in_byte == BYTE_PM || in_byte == BYTE_APC) begin
          mode_nxt = MODE_STRING;
        end else if (in_byte >= 8'h20 && in_byte <= 8'h2F) begin
          mode_nxt = MODE_INTERMED;
        end else begin
          mode_nxt = MODE_GROUND;
        end
      end
      MODE_CSI: begin
        if (in_byte >= 8'h20 && in_byte <= 8'h3F) begin
          mode_nxt = MODE_CSI;
        end else if (in_byte >= 8'h40 && in_byte <= 8'h7E) begin
          mode_nxt = MODE_GROUND;
        end else begin
          run_ground = 1'b1;
        end
      end
      MODE_STRING: begin
        if (in_byte == BYTE_BEL) begin
          mode_nxt = MODE_GROUND;
        end else if (in_byte == BYTE_ESC) begin
          mode_nxt = MODE_ESC_START;
        end
      end
      MODE_INTERMED: begin
        if (!(in_byte >= 8'h20 && in_byte <= 8'h2F)) mode_nxt = MODE_GROUND;
      end
      default: begin
        run_ground = 1'b1;
      end
    endcase

    // Ground handling, also used when a byte breaks a sequence or a CSI body.
    if (run_ground) begin
      mode_nxt = MODE_GROUND;
      if (in_byte == BYTE_LF) begin
        emit.count = 4'd1;
        emit.bytes = {BYTE_SPACE, BYTE_SPACE, BYTE_SPACE, in_byte};
      end else if (in_byte == BYTE_TAB) begin
        emit.count = tab_count;
      end else if (in_byte == BYTE_ESC) begin
        mode_nxt = MODE_ESC_START;
      end else if (in_byte < BYTE_SPACE || in_byte == BYTE_DEL) begin
        emit.count = '0;
      end else if (in_byte < 8'h80) begin
        emit.count = 4'd1;
        emit.bytes = {BYTE_SPACE, BYTE_SPACE, BYTE_SPACE, in_byte};
      end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
        mode_nxt    = MODE_UTF8;
        held_nxt[0] = in_byte;
        hcnt_nxt    = 2'd1;
        need_nxt    = 2'd1;
        cp_nxt      = {16'h0, in_byte[4:0]};
      end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
        mode_nxt    = MODE_UTF8;
        held_nxt[0] = in_byte;
        hcnt_nxt    = 2'd1;
        need_nxt    = 2'd2;
        cp_nxt      = {17'h0, in_byte[3:0]};
      end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
        mode_nxt    = MODE_UTF8;
        held_nxt[0] = in_byte;
        hcnt_nxt    = 2'd1;
        need_nxt    = 2'd3;
        cp_nxt      = {18'h0, in_byte[2:0]};
      end
    end

    // End of text drops any partial escape or sequence.
    if (end_of_text) begin
      mode_nxt = MODE_GROUND;
      need_nxt = 2'd0;
      hcnt_nxt = 2'd0;
      cp_nxt   = '0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GROUND;
      need_r <= 2'd0;
      hcnt_r <= 2'd0;
      cp_r   <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      need_r <= need_nxt;
      hcnt_r <= hcnt_nxt;
      cp_r   <= cp_nxt;
    end
  end

  // Collected sequence bytes; only entries of the current sequence are read.
  always_ff @(posedge clk) begin
    if (take) held_r <= held_nxt;
  end

`ifndef SYNTHESIS
  // While collecting, at least one continuation byte is still expected.
  a_utf8_need: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_UTF8 |-> need_r != 2'd0)
    else $error("tts_parse: collecting with no byte needed");

  // A sequence never holds more than four bytes in total.
  a_utf8_len: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_UTF8 |-> (hcnt_r != 2'd0 && ({1'b0, hcnt_r} + {1'b0, need_r}) <= 3'd4))
    else $error("tts_parse: sequence length out of range");

  // End of text always returns the parser to ground.
  a_eot_ground: assert property (@(posedge clk) disable iff (!rst_n)
    take && end_of_text |=> mode_r == MODE_GROUND && need_r == 2'd0)
    else $error("tts_parse: parser not in ground after end of text");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for terminal_text_sanitizer_core: a queue-fed stream driver,
// a monitor with a built-in byte-level predictor, and phases at several tab widths.
// Depends only on the RTL top level; no files are read.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Byte codes used by the predictor and the stimulus.
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_DCS   = 8'h50;
  localparam logic [7:0] CH_SOS   = 8'h58;
  localparam logic [7:0] CH_PM    = 8'h5E;
  localparam logic [7:0] CH_APC   = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int NUM_IGNORABLE = 19;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;

  typedef enum logic [2:0] {
    P_GROUND, P_UTF8, P_ESC, P_CSI, P_STRING, P_INTER
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } clean_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;

  terminal_text_sanitizer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [7:0] in_byte
    .in_tlast  (in_tlast),   // end_of_text
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [7:0] out_byte
    .out_tlast (out_tlast),  // out_last
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)   // tab_width
  );

  text_item_t  text_q[$];     // bytes waiting to be sent
  clean_byte_t clean_q[$];    // cleaned bytes still expected
  logic [7:0]  step_bytes[$]; // bytes caused by the byte being predicted
  text_item_t  next_item;
  logic        steady = 1'b0; // no idling on either side while set
  int          errs = 0;
  int          queued = 0;
  int          stall_cnt = 0;

  // Predictor state, at its reset values.
  parse_mode_t ps_mode = P_GROUND;
  logic [7:0]  ps_held [0:2];
  logic [1:0]  ps_need = 2'd0;
  logic [1:0]  ps_count = 2'd0;
  logic [20:0] ps_cp = 21'd0;
  logic [3:0]  tab_w = 4'd4;

  // Bounds of the ignorable codepoint ranges.
  function automatic void ign_bounds(input int k, output logic [20:0] lo,
                                     output logic [20:0] hi);
    case (k)
      0:  begin lo = 21'h000AD; hi = 21'h000AD; end
      1:  begin lo = 21'h0034F; hi = 21'h0034F; end
      2:  begin lo = 21'h0061C; hi = 21'h0061C; end
      3:  begin lo = 21'h0115F; hi = 21'h01160; end
      4:  begin lo = 21'h017B4; hi = 21'h017B5; end
      5:  begin lo = 21'h0180B; hi = 21'h0180F; end
      6:  begin lo = 21'h0200B; hi = 21'h0200F; end
      7:  begin lo = 21'h0202A; hi = 21'h0202E; end
      8:  begin lo = 21'h02060; hi = 21'h0206F; end
      9:  begin lo = 21'h020E3; hi = 21'h020E3; end
      10: begin lo = 21'h03164; hi = 21'h03164; end
      11: begin lo = 21'h0FE00; hi = 21'h0FE0F; end
      12: begin lo = 21'h0FEFF; hi = 21'h0FEFF; end
      13: begin lo = 21'h0FFA0; hi = 21'h0FFA0; end
      14: begin lo = 21'h0FFF0; hi = 21'h0FFF8; end
      15: begin lo = 21'h1BCA0; hi = 21'h1BCA3; end
      16: begin lo = 21'h1D173; hi = 21'h1D17A; end
      17: begin lo = 21'h1F3FB; hi = 21'h1F3FF; end
      default: begin lo = 21'hE0000; hi = 21'hE0FFF; end
    endcase
  endfunction

  function automatic logic is_ignorable(input logic [20:0] cp);
    logic [20:0] lo, hi;
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_IGNORABLE; k++) begin
      ign_bounds(k, lo, hi);
      if (cp >= lo && cp <= hi) hit = 1'b1;
    end
    return hit;
  endfunction

  // One input byte never causes more than eight output bytes.
  function automatic void put_byte(input logic [7:0] v);
    if (step_bytes.size() < 8) step_bytes.push_back(v);
  endfunction

  function automatic void open_seq(input logic [7:0] b, input logic [1:0] need,
                                   input logic [20:0] bits);
    ps_held[0] = b;
    ps_count   = 2'd1;
    ps_need    = need;
    ps_cp      = bits;
    ps_mode    = P_UTF8;
  endfunction

  // Handling of a byte seen in the ground state.
  function automatic void from_ground(input logic [7:0] b);
    ps_mode = P_GROUND;
    if (b == CH_LF) begin
      put_byte(b);
    end else if (b == CH_TAB) begin
      for (int t = 0; t < tab_w; t++) put_byte(CH_SPACE);
    end else if (b == CH_ESC) begin
      ps_mode = P_ESC;
    end else if (b < 8'h20 || b == CH_DEL) begin
      // Other controls are dropped.
    end else if (b < 8'h80) begin
      put_byte(b);
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      open_seq(b, 2'd1, {16'd0, b[4:0]});
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      open_seq(b, 2'd2, {17'd0, b[3:0]});
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      open_seq(b, 2'd3, {18'd0, b[2:0]});
    end
  endfunction

  // Final continuation byte: validate the codepoint and re-emit it, drop it, or give a space for a separator.
  function automatic void close_seq(input logic [7:0] b);
    logic [20:0] cp;
    int          len;
    logic        bad;
    cp  = ps_cp;
    len = ps_count + 1;
    bad = (len == 2 && cp < 21'h80) || (len == 3 && cp < 21'h800) ||
          (len == 4 && cp < 21'h10000) || (cp >= 21'hD800 && cp <= 21'hDFFF) ||
          cp > 21'h10FFFF;
    ps_mode = P_GROUND;
    ps_need = 2'd0;
    if (bad || (cp >= 21'h80 && cp <= 21'h9F)) return;
    if (cp == 21'h2028 || cp == 21'h2029) begin
      put_byte(CH_SPACE);
      return;
    end
    if (is_ignorable(cp)) return;
    for (int k = 0; k < ps_count && k < 3; k++) put_byte(ps_held[k]);
    put_byte(b);
  endfunction

  // Advances the predictor by one accepted byte and queues its cleaned bytes.
  function automatic void sanitize_byte(input logic [7:0] b, input logic eot);
    clean_byte_t r;
    step_bytes.delete();
    case (ps_mode)
      P_UTF8: begin
        if (b[7:6] == 2'b10) begin
          ps_cp = {ps_cp[14:0], b[5:0]};
          if (ps_need > 2'd1) begin
            ps_need = ps_need - 2'd1;
            if (ps_count < 2'd3) ps_held[ps_count] = b;
            ps_count = ps_count + 2'd1;
          end else begin
            close_seq(b);
          end
        end else begin
          from_ground(b);
        end
      end
      P_ESC: begin
        if (b == CH_LBRK)
          ps_mode = P_CSI;
        else if (b == CH_RBRK || b == CH_DCS || b == CH_SOS || b == CH_PM || b == CH_APC)
          ps_mode = P_STRING;
        else if (b >= 8'h20 && b <= 8'h2F)
          ps_mode = P_INTER;
        else
          ps_mode = P_GROUND;
      end
      P_CSI: begin
        if (b >= 8'h20 && b <= 8'h3F)
          ps_mode = P_CSI;
        else if (b >= 8'h40 && b <= 8'h7E)
          ps_mode = P_GROUND;
        else
          from_ground(b);
      end
      P_STRING: begin
        if (b == CH_BEL)
          ps_mode = P_GROUND;
        else if (b == CH_ESC)
          ps_mode = P_ESC;
      end
      P_INTER: begin
        if (!(b >= 8'h20 && b <= 8'h2F)) ps_mode = P_GROUND;
      end
      default: from_ground(b);
    endcase
    if (eot) begin
      ps_mode  = P_GROUND;
      ps_need  = 2'd0;
      ps_count = 2'd0;
      ps_cp    = 21'd0;
    end
    foreach (step_bytes[i]) begin
      r.ch   = step_bytes[i];
      r.last = (i == step_bytes.size() - 1);
      clean_q.push_back(r);
    end
  endfunction

  // Stimulus helpers.
  function automatic void push_item(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.b   = b;
    it.eot = eot;
    text_q.push_back(it);
    queued++;
  endfunction

  function automatic logic rand_eot();
    return $urandom_range(99) < 3;
  endfunction

  // Pushes the first keep bytes of a len-byte encoding of cp.
  function automatic void push_utf8(input logic [20:0] cp, input int len, input int keep);
    logic [7:0] enc [0:3];
    case (len)
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep && i < len; i++) push_item(enc[i], rand_eot());
  endfunction

  function automatic int natural_len(input logic [20:0] cp);
    return (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
  endfunction

  // Codepoints at the edges of the decoder's rules, with the length to encode them.
  function automatic void pick_edge_cp(output logic [20:0] cp, output int len);
    logic [20:0] lo, hi;
    case ($urandom_range(5))
      0: begin
        ign_bounds($urandom_range(NUM_IGNORABLE - 1), lo, hi);
        case ($urandom_range(3))
          0: cp = lo - 21'd1;
          1: cp = lo;
          2: cp = hi;
          default: cp = hi + 21'd1;
        endcase
        len = natural_len(cp);
      end
      1: begin cp = $urandom_range(1) ? 21'h2028 : 21'h2029; len = 3; end
      2: begin cp = 21'($urandom_range(21'h7E, 21'hA0)); len = 2; end
      3: begin cp = 21'($urandom_range(21'hD7FF, 21'hE000)); len = 3; end
      4: begin cp = 21'($urandom_range(21'h10FFFF, 21'h1FFFFF)); len = 4; end
      default: begin
        len = $urandom_range(2, 4);
        if (len == 2) cp = 21'($urandom_range(21'h7F));
        else if (len == 3) cp = 21'($urandom_range(21'h7FF));
        else cp = 21'($urandom_range(21'hFFFF));
      end
    endcase
  endfunction

  // Adds one random chunk: mostly well-formed text, escapes and UTF-8, some noise.
  function automatic void add_chunk();
    int          pick, n, len;
    logic [20:0] cp;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 20) begin
      push_item(8'($urandom_range(8'h20, 8'h7E)), rand_eot());
    end else if (pick < 30) begin
      case ($urandom_range(4))
        0: b = CH_TAB;
        1: b = CH_LF;
        2: b = CH_DEL;
        3: b = CH_ESC;
        default: b = 8'($urandom_range(8'h1F));
      endcase
      push_item(b, rand_eot());
    end else if (pick < 55) begin
      len = $urandom_range(2, 4);
      if (len == 2) cp = 21'($urandom_range(21'h80, 21'h7FF));
      else if (len == 3) cp = 21'($urandom_range(21'h800, 21'hFFFF));
      else cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      push_utf8(cp, len, len);
    end else if (pick < 65) begin
      pick_edge_cp(cp, len);
      push_utf8(cp, len, len);
    end else if (pick < 72) begin
      // Sequence cut short by a byte that is not a continuation.
      len = $urandom_range(2, 4);
      push_utf8(21'($urandom_range(21'h800, 21'hFFFF)), len, $urandom_range(1, len - 1));
      b = 8'($urandom_range(8'hFF));
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      push_item(b, rand_eot());
    end else if (pick < 82) begin
      push_item(CH_ESC, rand_eot());
      push_item(CH_LBRK, rand_eot());
      n = $urandom_range(4);
      for (int i = 0; i < n; i++) push_item(8'($urandom_range(8'h20, 8'h3F)), rand_eot());
      if ($urandom_range(99) < 85) push_item(8'($urandom_range(8'h40, 8'h7E)), rand_eot());
      else push_item(8'($urandom_range(8'hFF)), rand_eot());
    end else if (pick < 88) begin
      push_item(CH_ESC, rand_eot());
      case ($urandom_range(4))
        0: b = CH_RBRK;
        1: b = CH_DCS;
        2: b = CH_SOS;
        3: b = CH_PM;
        default: b = CH_APC;
      endcase
      push_item(b, rand_eot());
      n = $urandom_range(6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) push_item(8'($urandom_range(8'hFF)), rand_eot());
        else push_item(8'($urandom_range(8'h20, 8'h7E)), rand_eot());
      end
      if ($urandom_range(1)) begin
        push_item(CH_BEL, rand_eot());
      end else begin
        push_item(CH_ESC, rand_eot());
        push_item(CH_BSLASH, rand_eot());
      end
    end else if (pick < 92) begin
      push_item(CH_ESC, rand_eot());
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) push_item(8'($urandom_range(8'h20, 8'h2F)), rand_eot());
      push_item(8'($urandom_range(8'h30, 8'h7E)), rand_eot());
    end else if (pick < 95) begin
      push_item(CH_ESC, rand_eot());
      push_item(8'($urandom_range(8'hFF)), rand_eot());
    end else begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        push_item(8'($urandom_range(8'hFF)), 1'($urandom_range(1)));
    end
  endfunction

  // Waits until everything sent has been answered, then lets the block settle.
  task automatic drain();
    do @(negedge clk); while (text_q.size() != 0 || in_tvalid || clean_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_tab(input logic [3:0] w);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [3:0] w, input int n, input logic no_idle);
    set_tab(w);
    @(negedge clk);
    steady = no_idle;
    queued = 0;
    push_item(CH_TAB, 1'b0);
    while (queued < n) add_chunk();
    drain();
    steady = 1'b0;
  endtask

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Input driver: presents the next queued byte, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (text_q.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
        next_item = text_q.pop_front();
        in_tdata  <= next_item.b;
        in_tlast  <= next_item.eot;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: tracks register writes, predicts on each input transfer and
  // checks each output transfer against the oldest expected byte.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (cfg_we) tab_w = cfg_wdata;
      if (in_tvalid && in_tready) sanitize_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (clean_q.size() == 0) begin
          if (errs < MAX_REPORTS)
            $display("ERROR: unexpected output byte %02h last %0b", out_tdata, out_tlast);
          errs++;
        end else begin
          clean_byte_t exp_b;
          exp_b = clean_q.pop_front();
          if (out_tdata !== exp_b.ch || out_tlast !== exp_b.last) begin
            if (errs < MAX_REPORTS)
              $display("ERROR: expected byte %02h last %0b, got byte %02h last %0b",
                       exp_b.ch, exp_b.last, out_tdata, out_tlast);
            errs++;
          end
        end
      end
      out_tready <= steady || $urandom_range(99) >= 23;
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // Sequencer: reset, directed bytes at the reset tab width, then random phases.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Tab, newline, a CSI sequence, DEL, NUL, plain ASCII.
    push_item(CH_TAB, 1'b0);
    push_item(CH_LF, 1'b0);
    push_item(CH_ESC, 1'b0);
    push_item(CH_LBRK, 1'b0);
    push_item(8'h33, 1'b0);
    push_item(8'h6D, 1'b0);
    push_item(CH_DEL, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h7E, 1'b0);
    // C1 control, line separator, surrogate, above the codepoint limit.
    push_utf8(21'h85, 2, 2);
    push_utf8(21'h2028, 3, 3);
    push_utf8(21'hD800, 3, 3);
    push_utf8(21'h110000, 4, 4);
    // A valid four-byte sequence, then a bad lead byte.
    push_utf8(21'h1F600, 4, 4);
    push_item(8'hFF, 1'b0);
    // Broken sequence: lead byte followed by ASCII.
    push_item(8'hE2, 1'b0);
    push_item(8'h41, 1'b0);
    // String sequence closed by ESC backslash; the backslash is swallowed.
    push_item(CH_ESC, 1'b0);
    push_item(CH_RBRK, 1'b0);
    push_item(CH_ESC, 1'b0);
    push_item(CH_BSLASH, 1'b0);
    // Partial sequence discarded at end of text.
    push_item(8'hC3, 1'b1);
    drain();

    // Random phases across tab widths, extremes included.
    run_phase(4'd0, 56, 1'b0);
    run_phase(4'd15, 56, 1'b1);
    run_phase(4'd8, 56, 1'b0);
    run_phase(4'd1, 56, 1'b0);
    run_phase(4'($urandom_range(15)), 56, 1'b0);

    repeat (20) @(negedge clk);
    if (clean_q.size() != 0)
      $display("ERROR: %0d expected bytes never arrived", clean_q.size());
    if (errs == 0 && clean_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

### terminal_text_sanitizer_core.f
rtl/core/tts_pkg.sv
rtl/core/tts_parse.sv
rtl/core/terminal_text_sanitizer_core.sv
dv/tb.sv
